/* rtl/core/fourier_series_evaluator_macros.svh */
// Assertion macros used by the checker file of the series evaluator.
`ifndef FOURIER_SERIES_EVALUATOR_MACROS_SVH
`define FOURIER_SERIES_EVALUATOR_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define FSE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define FSE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/fse_pkg.sv */
// Shared constants, types and table functions of the Fourier series evaluator.
`default_nettype none
package fse_pkg;

   localparam int MAX_DIMS        = 4;
   localparam int MAX_HARMONICS   = 64;
   localparam int SINE_TABLE_BITS = 10;

   localparam int DIM_W     = $clog2(MAX_DIMS);
   localparam int HARM_W    = $clog2(MAX_HARMONICS);
   localparam int ADDR_W    = DIM_W + HARM_W;
   localparam int RAM_DEPTH = MAX_DIMS * MAX_HARMONICS;
   localparam int DCNT_W    = $clog2(MAX_DIMS + 1);
   localparam int HCNT_W    = $clog2(MAX_HARMONICS + 1);
   localparam int COEF_W    = 32;

   localparam int ROM_QUARTER = 1 << (SINE_TABLE_BITS - 2);

   localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
   localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
   localparam logic [63:0] ONE_Q30    = 64'd1 << 30;

   // divider geometry
   localparam int QUOT_W = 34;
   localparam int REM_W  = 60;
   localparam int STEP_W = 6;
   localparam logic [STEP_W-1:0] STEPS_MOD  = STEP_W'(32);
   localparam logic [STEP_W-1:0] STEPS_IDX  = STEP_W'(SINE_TABLE_BITS + 1);
   localparam logic [STEP_W-1:0] STEPS_RATE = STEP_W'(QUOT_W);
   localparam int IDXN_W = 31 + SINE_TABLE_BITS + 1;

   // derivative term cap, 2^33
   localparam logic [QUOT_W-1:0] TERM_CAP = QUOT_W'(64'd1 << 33);

   localparam logic signed [65:0] SAT_MAX = 66'sh0_7FFF_FFFF;
   localparam logic signed [65:0] SAT_MIN = -66'sh0_8000_0000;

   typedef enum logic [1:0] {
      REQ_LOAD_TREND = 2'd0,
      REQ_LOAD_HARM  = 2'd1,
      REQ_EVAL       = 2'd2
   } req_code_type;

   typedef enum logic [2:0] {
      CSR_RAMP_MODE      = 3'd0,
      CSR_START_TIME     = 3'd1,
      CSR_PERIOD         = 3'd2,
      CSR_HARMONIC_COUNT = 3'd3,
      CSR_DIM_COUNT      = 3'd4
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_TIME, ST_TMOD, ST_DIM, ST_TREND, ST_HARM, ST_IDX, ST_MUL,
      ST_SUM, ST_RMUL, ST_RPART, ST_RJOIN, ST_RCHK, ST_RDIV, ST_RACC, ST_NEXT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic              start;
      logic [STEP_W-1:0] steps;
      logic [REM_W-1:0]  rinit;
      logic [QUOT_W-1:0] low;
      logic [REM_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quot;
      logic [REM_W-1:0]  rem;
   } div_rsp_type;

   typedef logic [16:0] qsine_type [ROM_QUARTER+1];

   // First-quadrant sine, Q16.16, from an 11th order Taylor series
   function automatic qsine_type build_qsine();
      qsine_type   tbl;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] tt;
      logic [63:0] s;
      for (int r = 0; r <= ROM_QUARTER; r++) begin
         x  = (64'(r) * TWO_PI_Q30) >> SINE_TABLE_BITS;
         x2 = (x * x) >> 30;
         tt = ONE_Q30 - x2 / 110;
         tt = ONE_Q30 - ((x2 * tt) >> 30) / 72;
         tt = ONE_Q30 - ((x2 * tt) >> 30) / 42;
         tt = ONE_Q30 - ((x2 * tt) >> 30) / 20;
         tt = ONE_Q30 - ((x2 * tt) >> 30) / 6;
         s  = (x * tt) >> 30;
         s  = (s + 64'd8192) >> 14;
         if (s > 64'd65536) begin
            s = 64'd65536;
         end
         tbl[r] = s[16:0];
      end
      return tbl;
   endfunction

   localparam qsine_type QSINE = build_qsine();

   // Full-turn sine from the quarter table
   function automatic logic signed [17:0] sine_lookup(input logic [SINE_TABLE_BITS-1:0] idx);
      logic [SINE_TABLE_BITS-2:0] ri;
      logic [16:0]                mag;
      ri = idx[SINE_TABLE_BITS-2]
         ? (SINE_TABLE_BITS-1)'(ROM_QUARTER) - {1'b0, idx[SINE_TABLE_BITS-3:0]}
         : {1'b0, idx[SINE_TABLE_BITS-3:0]};
      mag = QSINE[ri];
      return idx[SINE_TABLE_BITS-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [65:0] c;
      c = v;
      if (v > SAT_MAX) begin
         c = SAT_MAX;
      end
      if (v < SAT_MIN) begin
         c = SAT_MIN;
      end
      return c[31:0];
   endfunction

endpackage
`default_nettype wire

/* rtl/core/fse_ram.sv */
// Generic single-port-write, registered-read RAM.
`default_nettype none
module fse_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule
`default_nettype wire

/* rtl/core/fse_divider.sv */
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module fse_divider import fse_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output      div_rsp_type rsp
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [QUOT_W-1:0] low_ff, low_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [REM_W-1:0]  div_ff, div_in;
   logic [REM_W:0]    trial;
   logic              fits;

   // shift in the next dividend bit and try a subtract
   always_comb begin
      trial   = {rem_ff, low_ff[QUOT_W-1]};
      fits    = trial >= {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      quot_in = quot_ff;
      div_in  = div_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = req.steps;
         rem_in  = req.rinit;
         low_in  = req.low;
         quot_in = '0;
         div_in  = req.divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? REM_W'(trial - {1'b0, div_ff}) : REM_W'(trial);
         low_in  = {low_ff[QUOT_W-2:0], 1'b0};
         quot_in = {quot_ff[QUOT_W-2:0], fits};
         cnt_in  = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      quot_ff <= quot_in;
      div_ff  <= div_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;
   assign rsp.rem  = rem_ff;

endmodule
`default_nettype wire

/* rtl/core/fourier_series_evaluator.sv */
// Top level of the truncated Fourier series evaluator with linear trend.
//
// Input channel req_*: load items (offset/slope, or a cosine/sine pair for one
// dimension and harmonic) are written on acceptance; an evaluate item starts a
// run over all enabled dimensions. Result channel rsp_*: one transfer per
// dimension, rsp_last on the final one. Configuration goes through
// csr_we/csr_index/csr_wdata; the user must write it only while the block is
// idle, which the block itself does not enforce. An evaluate item first wraps
// the time into the period with a 32-step divide, then per dimension forms the
// trend and, per harmonic, finds the table phase with an 11-step divide and
// adds the cosine/sine products; when a derivative is requested for a harmonic
// above zero, a 34-step divide forms the derivative term unless it clamps; all
// divides use the shared divider. Ramp mode clamps the time and skips harmonics.
// Items are worked one at a time; req_ready is high only between items.
// A result register parts the channels: a new item is accepted while the last
// result still waits, and a stalled receiver holds the run at that point.
// Reset clears the configuration to its defaults and all tables to zero
// (coefficient entries carry valid bits), and drops rsp_valid.
`default_nettype none
module fourier_series_evaluator import fse_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire logic [1:0]         req_type,
   input  wire logic [1:0]         req_dim_index,
   input  wire logic [5:0]         req_harmonic_index,
   input  wire logic signed [31:0] req_coef_a,
   input  wire logic signed [31:0] req_coef_b,
   input  wire logic signed [31:0] req_sample_time,
   input  wire logic               req_want_derivative,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      logic [1:0]         rsp_out_dim,
   output      logic signed [31:0] rsp_out_value,
   output      logic signed [31:0] rsp_out_derivative,
   output      logic               rsp_last,
   input  wire logic               csr_we,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_wdata
);

   // configuration
   logic               ramp_mode_ff;
   logic signed [31:0] start_time_ff;
   logic [30:0]        period_ff;
   logic [6:0]         harmonic_count_ff;
   logic [2:0]         dim_count_ff;

   logic signed [31:0] offset_ff [MAX_DIMS];
   logic signed [31:0] slope_ff  [MAX_DIMS];
   logic [RAM_DEPTH-1:0] coef_valid_ff;

   state_type state_ff, state_in;

   // datapath
   logic                      want_ff;
   logic signed [32:0]        t_raw_ff;
   logic signed [31:0]        t_ff;
   logic [30:0]               tpos_ff;
   logic [DCNT_W-1:0]         d_ff;
   logic [HCNT_W-1:0]         k_ff;
   logic [30:0]               ph_ff;
   logic signed [63:0]        trend_ff;
   logic signed [65:0]        acc_ff;
   logic signed [41:0]        dacc_ff;
   logic [SINE_TABLE_BITS-1:0] idx_ff;
   logic                      vld_rd_ff;
   logic signed [49:0]        pr_cc_c_ff, pr_sc_s_ff, pr_cc_s_ff, pr_sc_c_ff;
   logic [48:0]               mag_ff;
   logic                      msign_ff;
   logic [54:0]               a_ff;
   logic [59:0]               nhi_ff;
   logic [58:0]               nlo_ff;
   logic [86:0]               n_ff;
   logic [QUOT_W-1:0]         term_ff;

   // result register
   logic               rsp_valid_ff;
   logic [1:0]         out_dim_ff;
   logic signed [31:0] out_value_ff;
   logic signed [31:0] out_deriv_ff;
   logic               out_last_ff;

   // control
   logic        accept;
   logic        ram_re;
   logic        out_load;
   div_req_type div_req;
   div_rsp_type div_rsp;

   logic [30:0]            pe;
   logic [DCNT_W-1:0]      nd;
   logic [HCNT_W-1:0]      nh;
   logic                   load_ok;
   logic                   harm_ok;
   logic [ADDR_W-1:0]      waddr;
   logic [ADDR_W-1:0]      raddr;
   logic [2*COEF_W-1:0]    ram_rdata;
   logic signed [31:0]     cc, sc;
   logic signed [17:0]     sn, cs;
   logic signed [50:0]     msum;
   logic [IDXN_W-1:0]      idx_num;
   logic [31:0]            tabs;
   logic [52:0]            n_hi;
   logic [REM_W-1:0]       rate_div;
   logic                   rate_clamp;
   logic [31:0]            ph_sum;
   logic [30:0]            rem31;
   logic                   last_dim;
   logic                   last_harm;

   // effective period and counts
   assign pe = (period_ff == 31'd0) ? 31'd1 : period_ff;
   assign nd = ({1'b0, dim_count_ff} > 4'(MAX_DIMS)) ? DCNT_W'(MAX_DIMS)
             : DCNT_W'(dim_count_ff);
   assign nh = ({1'b0, harmonic_count_ff} > 8'(MAX_HARMONICS)) ? HCNT_W'(MAX_HARMONICS)
             : HCNT_W'(harmonic_count_ff);

   assign accept  = req_valid && req_ready;
   assign load_ok = 32'(req_dim_index) < MAX_DIMS;
   assign harm_ok = load_ok && (32'(req_harmonic_index) < MAX_HARMONICS);
   assign waddr   = {req_dim_index[DIM_W-1:0], req_harmonic_index[HARM_W-1:0]};
   assign raddr   = {d_ff[DIM_W-1:0], k_ff[HARM_W-1:0]};

   assign last_dim  = (d_ff + DCNT_W'(1)) == nd;
   assign last_harm = (k_ff + HCNT_W'(1)) == nh;

   // coefficient store: cosine in the upper word, sine in the lower
   fse_ram #(
      .WIDTH (2 * COEF_W),
      .DEPTH (RAM_DEPTH)
   ) u_coef_ram (
      .clock (clock),
      .we    (accept && (req_type == REQ_LOAD_HARM) && harm_ok),
      .waddr (waddr),
      .wdata ({req_coef_a, req_coef_b}),
      .re    (ram_re),
      .raddr (raddr),
      .rdata (ram_rdata)
   );

   fse_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // operand shaping
   assign tabs     = t_raw_ff[32] ? 32'(-t_raw_ff) : t_raw_ff[31:0];
   assign idx_num  = {ph_ff, {(SINE_TABLE_BITS+1){1'b0}}} + IDXN_W'(pe);
   assign n_hi     = n_ff[86:QUOT_W];
   assign rate_div = {pe, 29'd0};
   assign rate_clamp = {7'd0, n_hi} >= rate_div;
   assign cc       = vld_rd_ff ? $signed(ram_rdata[2*COEF_W-1:COEF_W]) : 32'sd0;
   assign sc       = vld_rd_ff ? $signed(ram_rdata[COEF_W-1:0]) : 32'sd0;
   assign sn       = sine_lookup(idx_ff);
   assign cs       = sine_lookup(idx_ff + SINE_TABLE_BITS'(ROM_QUARTER));
   assign msum     = 51'(pr_cc_s_ff) + 51'(pr_sc_c_ff);
   assign ph_sum   = {1'b0, ph_ff} + {1'b0, tpos_ff};
   assign rem31    = div_rsp.rem[30:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_type == REQ_EVAL) && (nd != '0)) begin
               state_in = ST_TIME;
            end
         end
         ST_TIME:  state_in = ramp_mode_ff ? ST_DIM : ST_TMOD;
         ST_TMOD:  if (div_rsp.done) state_in = ST_DIM;
         ST_DIM:   state_in = ST_TREND;
         ST_TREND: state_in = (ramp_mode_ff || (nh == '0)) ? ST_OUT : ST_HARM;
         ST_HARM:  state_in = ST_IDX;
         ST_IDX:   if (div_rsp.done) state_in = ST_MUL;
         ST_MUL:   state_in = ST_SUM;
         ST_SUM:   state_in = (want_ff && (k_ff != '0)) ? ST_RMUL : ST_NEXT;
         ST_RMUL:  state_in = ST_RPART;
         ST_RPART: state_in = ST_RJOIN;
         ST_RJOIN: state_in = ST_RCHK;
         ST_RCHK:  state_in = rate_clamp ? ST_RACC : ST_RDIV;
         ST_RDIV:  if (div_rsp.done) state_in = ST_RACC;
         ST_RACC:  state_in = ST_NEXT;
         ST_NEXT:  state_in = last_harm ? ST_OUT : ST_HARM;
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = last_dim ? ST_IDLE : ST_DIM;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready = 1'b0;
      ram_re    = 1'b0;
      out_load  = 1'b0;
      div_req   = '0;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_TIME: begin
            div_req.start   = !ramp_mode_ff;
            div_req.steps   = STEPS_MOD;
            div_req.rinit   = '0;
            div_req.low     = {tabs, 2'b00};
            div_req.divisor = REM_W'(pe);
         end
         ST_HARM: begin
            ram_re          = 1'b1;
            div_req.start   = 1'b1;
            div_req.steps   = STEPS_IDX;
            div_req.rinit   = REM_W'(idx_num >> (SINE_TABLE_BITS + 1));
            div_req.low     = {idx_num[SINE_TABLE_BITS:0],
                               {(QUOT_W-SINE_TABLE_BITS-1){1'b0}}};
            div_req.divisor = REM_W'({pe, 1'b0});
         end
         ST_RCHK: begin
            div_req.start   = !rate_clamp;
            div_req.steps   = STEPS_RATE;
            div_req.rinit   = REM_W'(n_hi);
            div_req.low     = n_ff[QUOT_W-1:0];
            div_req.divisor = rate_div;
         end
         ST_OUT:  out_load = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_mode_ff      <= 1'b0;
         start_time_ff     <= '0;
         period_ff         <= 31'd65536;
         harmonic_count_ff <= 7'd1;
         dim_count_ff      <= 3'd1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RAMP_MODE:      ramp_mode_ff      <= csr_wdata[0];
            CSR_START_TIME:     start_time_ff     <= $signed(csr_wdata);
            CSR_PERIOD:         period_ff         <= csr_wdata[30:0];
            CSR_HARMONIC_COUNT: harmonic_count_ff <= csr_wdata[6:0];
            CSR_DIM_COUNT:      dim_count_ff      <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   // trend table and coefficient valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_DIMS; i++) begin
            offset_ff[i] <= '0;
            slope_ff[i]  <= '0;
         end
         coef_valid_ff <= '0;
      end else if (accept) begin
         if ((req_type == REQ_LOAD_TREND) && load_ok) begin
            offset_ff[req_dim_index[DIM_W-1:0]] <= req_coef_a;
            slope_ff[req_dim_index[DIM_W-1:0]]  <= req_coef_b;
         end
         if ((req_type == REQ_LOAD_HARM) && harm_ok) begin
            coef_valid_ff[waddr] <= 1'b1;
         end
      end
   end

   // evaluation datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            want_ff  <= req_want_derivative;
            t_raw_ff <= 33'(req_sample_time) - 33'(start_time_ff);
            d_ff     <= '0;
         end
         ST_TIME: begin
            if (t_raw_ff > $signed({2'b00, pe})) begin
               t_ff <= $signed({1'b0, pe});
            end else if (t_raw_ff < 33'sd0) begin
               t_ff <= '0;
            end else begin
               t_ff <= t_raw_ff[31:0];
            end
         end
         ST_TMOD: begin
            t_ff    <= t_raw_ff[32] ? -$signed({1'b0, rem31}) : $signed({1'b0, rem31});
            tpos_ff <= (t_raw_ff[32] && (rem31 != '0)) ? pe - rem31 : rem31;
         end
         ST_DIM: begin
            trend_ff <= t_ff * slope_ff[d_ff[DIM_W-1:0]];
            dacc_ff  <= 42'(slope_ff[d_ff[DIM_W-1:0]]);
            k_ff     <= '0;
            ph_ff    <= '0;
         end
         ST_TREND: begin
            acc_ff <= $signed({{18{offset_ff[d_ff[DIM_W-1:0]][31]}},
                               offset_ff[d_ff[DIM_W-1:0]], 16'd0}) + 66'(trend_ff);
         end
         ST_HARM: begin
            vld_rd_ff <= coef_valid_ff[raddr];
         end
         ST_IDX: begin
            idx_ff <= div_rsp.quot[SINE_TABLE_BITS-1:0];
         end
         ST_MUL: begin
            pr_cc_c_ff <= cc * cs;
            pr_sc_s_ff <= sc * sn;
            pr_cc_s_ff <= cc * sn;
            pr_sc_c_ff <= sc * cs;
         end
         ST_SUM: begin
            acc_ff   <= acc_ff + 66'(pr_cc_c_ff) - 66'(pr_sc_s_ff);
            msign_ff <= msum[50];
            mag_ff   <= msum[50] ? 49'(-msum) : msum[48:0];
         end
         ST_RMUL: begin
            a_ff <= mag_ff * k_ff[HARM_W-1:0];
         end
         ST_RPART: begin
            nhi_ff <= a_ff[54:27] * TWO_PI_Q29;
            nlo_ff <= a_ff[26:0] * TWO_PI_Q29;
         end
         ST_RJOIN: begin
            n_ff <= {nhi_ff, 27'd0} + 87'(nlo_ff);
         end
         ST_RCHK: begin
            term_ff <= TERM_CAP;
         end
         ST_RDIV: begin
            term_ff <= (div_rsp.quot > TERM_CAP) ? TERM_CAP : div_rsp.quot;
         end
         ST_RACC: begin
            dacc_ff <= msign_ff ? dacc_ff + 42'(term_ff) : dacc_ff - 42'(term_ff);
         end
         ST_NEXT: begin
            k_ff  <= k_ff + HCNT_W'(1);
            ph_ff <= (ph_sum >= {1'b0, pe}) ? 31'(ph_sum - {1'b0, pe}) : ph_sum[30:0];
         end
         ST_OUT: begin
            if (out_load) begin
               d_ff <= d_ff + DCNT_W'(1);
            end
         end
         default: ;
      endcase
   end

   // result register: hold until transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_dim_ff   <= 2'(d_ff);
         out_value_ff <= sat32(acc_ff >>> 16);
         out_deriv_ff <= want_ff ? sat32(66'(dacc_ff)) : 32'sd0;
         out_last_ff  <= last_dim;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_dim        = out_dim_ff;
   assign rsp_out_value      = out_value_ff;
   assign rsp_out_derivative = out_deriv_ff;
   assign rsp_last           = out_last_ff;

endmodule
`default_nettype wire

/* rtl/core/fse_checker.sv */
// Port-level checks for the Fourier series evaluator, bound to the top level.
`default_nettype none
`include "fourier_series_evaluator_macros.svh"
module fse_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_out_dim,
   input wire logic [31:0] rsp_out_value,
   input wire logic [31:0] rsp_out_derivative,
   input wire logic        rsp_last
);

   // a stalled result holds
   `FSE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable({rsp_out_dim, rsp_out_value, rsp_out_derivative, rsp_last}), "stalled result changed")

   // the run is still busy while a non-final result is shown
   `FSE_ASSERT_NOW(a_busy_mid_run, rsp_valid && !rsp_last, !req_ready, "input ready in mid run")

   // dimensions follow in order within a run
   `FSE_ASSERT_NEXT(a_dim_order, rsp_valid && rsp_ready && !rsp_last, !rsp_valid || (rsp_out_dim == $past(rsp_out_dim) + 2'd1), "dimension out of order")

endmodule

bind fourier_series_evaluator fse_checker u_fse_checker (.*);
`default_nettype wire
